// ===== src/manchester_frame_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// Manchester frame encoder assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MANCHESTER_FRAME_ENCODER_DEFINES_SVH
`define MANCHESTER_FRAME_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define MFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define MFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Manchester frame encoder package
// Item modes, byte constants, controller/datapath command and status types and the
// nibble coding function.
// ----------------------------------------------------------------------------
package mfe_pkg;

    // Input item modes
    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_PAYLOAD = 2'd1,
        MODE_END     = 2'd2
    } mode_t;

    // Frame bytes
    localparam logic [7:0] HEADER_BYTE  = 8'h1F;
    localparam logic [7:0] TRAILER_BYTE = 8'h00;
    localparam logic [1:0] PAIR_ONE     = 2'b01;
    localparam logic [1:0] PAIR_ZERO    = 2'b10;

    // Source of the next output byte
    typedef enum logic [2:0] {
        SEL_HEADER  = 3'd0,
        SEL_IN_HI   = 3'd1,
        SEL_VAL_HI  = 3'd2,
        SEL_VAL_LO  = 3'd3,
        SEL_PAD     = 3'd4,
        SEL_TRAILER = 3'd5
    } byte_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        byte_sel_t sel;
        logic      capture;
        logic      open_frame;
        logic      close_frame;
        logic      inc_count;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic in_frame;
        logic count_full;
        logic count_last;
    } dp_status_t;

    // Code a nibble MSB first: 1 -> 01, 0 -> 10
    function automatic logic [7:0] code_nibble(input logic [3:0] nib);
        logic [7:0] acc;
        acc = '0;
        for (int k = 3; k >= 0; k--)
        begin
            acc = {acc[5:0], (nib[k] ? PAIR_ONE : PAIR_ZERO)};
        end
        return acc;
    endfunction

endpackage

// ===== src/mfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// Manchester frame encoder controller
// Sequences the output bytes of each item and gates input acceptance.
// ----------------------------------------------------------------------------
module mfe_ctrl
    import mfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [1:0] mode,
    output logic       item_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_HI     = 7'b0000010,
        ST_LO     = 7'b0000100,
        ST_PAD_HI = 7'b0001000,
        ST_PAD_LO = 7'b0010000,
        ST_TRAIL  = 7'b0100000,
        ST_SPARE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Take an item only when idle and the output slot can take its first byte
    assign item_stall = !((state_reg == ST_IDLE) && status.out_free);
    assign accept     = item_valid && !item_stall;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '{load: 1'b0, sel: SEL_HEADER, capture: 1'b0, open_frame: 1'b0,
                       close_frame: 1'b0, inc_count: 1'b0};
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_START:
                        begin
                            cmd.load       = 1'b1;
                            cmd.sel        = SEL_HEADER;
                            cmd.capture    = 1'b1;
                            cmd.open_frame = 1'b1;
                            state_next     = ST_HI;
                        end
                        MODE_PAYLOAD:
                        begin
                            if (status.in_frame && !status.count_full)
                            begin
                                cmd.load      = 1'b1;
                                cmd.sel       = SEL_IN_HI;
                                cmd.capture   = 1'b1;
                                cmd.inc_count = 1'b1;
                                state_next    = ST_LO;
                            end
                        end
                        MODE_END:
                        begin
                            if (status.in_frame)
                            begin
                                cmd.load = 1'b1;
                                if (status.count_full)
                                begin
                                    cmd.sel         = SEL_TRAILER;
                                    cmd.close_frame = 1'b1;
                                end
                                else
                                begin
                                    cmd.sel    = SEL_PAD;
                                    state_next = ST_PAD_LO;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_HI:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.sel    = SEL_VAL_HI;
                    state_next = ST_LO;
                end
            end
            ST_LO:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.sel    = SEL_VAL_LO;
                    state_next = ST_IDLE;
                end
            end
            ST_PAD_HI:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.sel    = SEL_PAD;
                    state_next = ST_PAD_LO;
                end
            end
            ST_PAD_LO:
            begin
                if (status.out_free)
                begin
                    cmd.load      = 1'b1;
                    cmd.sel       = SEL_PAD;
                    cmd.inc_count = 1'b1;
                    state_next    = status.count_last ? ST_TRAIL : ST_PAD_HI;
                end
            end
            ST_TRAIL:
            begin
                if (status.out_free)
                begin
                    cmd.load        = 1'b1;
                    cmd.sel         = SEL_TRAILER;
                    cmd.close_frame = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/mfe_datapath.sv =====
// ----------------------------------------------------------------------------
// Manchester frame encoder datapath
// Holds the frame state, the captured byte and the output register.
// ----------------------------------------------------------------------------
module mfe_datapath
    import mfe_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] byte_value,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic [7:0] out_byte,
    output logic       last,
    output logic       result_valid,
    input  logic       result_stall
);

    localparam int CW = $clog2(PAYLOAD_BYTES + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          in_frame_reg;
    logic          in_frame_next;
    logic [7:0]    val_reg;
    logic [7:0]    out_byte_reg;
    logic          last_reg;
    logic          valid_reg;
    logic          valid_next;
    logic [7:0]    byte_next;

    // Status back to the controller
    assign status.out_free   = !valid_reg || !result_stall;
    assign status.in_frame   = in_frame_reg;
    assign status.count_full = (count_reg == CW'(PAYLOAD_BYTES));
    assign status.count_last = (count_reg == CW'(PAYLOAD_BYTES - 1));

    // Output byte select
    always_comb
    begin
        case (cmd.sel)
            SEL_HEADER:  byte_next = HEADER_BYTE;
            SEL_IN_HI:   byte_next = code_nibble(byte_value[7:4]);
            SEL_VAL_HI:  byte_next = code_nibble(val_reg[7:4]);
            SEL_VAL_LO:  byte_next = code_nibble(val_reg[3:0]);
            SEL_PAD:     byte_next = code_nibble(4'h0);
            SEL_TRAILER: byte_next = TRAILER_BYTE;
            default:     byte_next = TRAILER_BYTE;
        endcase
    end

    // Frame state update
    always_comb
    begin
        count_next    = count_reg;
        in_frame_next = in_frame_reg;
        if (cmd.open_frame || cmd.close_frame)
        begin
            count_next    = '0;
            in_frame_next = cmd.open_frame;
        end
        else if (cmd.inc_count)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // Output slot: filled on load, emptied when the transaction completes
    always_comb
    begin
        if (cmd.load)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            in_frame_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            in_frame_reg <= in_frame_next;
            valid_reg    <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            val_reg <= byte_value;
        end
        if (cmd.load)
        begin
            out_byte_reg <= byte_next;
            last_reg     <= (cmd.sel == SEL_TRAILER);
        end
    end

    assign out_byte     = out_byte_reg;
    assign last         = last_reg;
    assign result_valid = valid_reg;

endmodule

// ===== src/manchester_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// Manchester frame encoder
// Turns start / payload / end items into a Manchester-coded transmit frame.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid / item_stall, mode, byte_value): start carries
//   the frame number, payload one data byte, end closes the message.
//   Result channel (result_valid / result_stall, out_byte, last): one frame
//   byte per transaction, last set on the trailer byte 0x00.
//   The first result of an item is in the output register in the cycle after
//   the item is taken, then one byte per cycle while the receiver takes them.
//   Output bytes per item: start 3, payload 2, end 2*(PAYLOAD_BYTES - bytes
//   so far) + 1, an item that gives nothing 0. The controller emits one byte
//   per cycle through the single output register while the receiver takes
//   them; the next item can be taken, at the earliest, in the cycle after
//   the last byte of the current one is loaded.
//   Reset clears the frame state and empties the output register; no frame
//   is open afterwards.
//   While a byte waits in the output register under result_stall, it holds,
//   the sequencer waits and item_stall stays high.
// ----------------------------------------------------------------------------
module manchester_frame_encoder
    import mfe_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [1:0] mode,
    input  logic [7:0] byte_value,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte,
    output logic       last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Byte sequencer
    mfe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .mode       (mode),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // Frame state and output register
    mfe_datapath #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_value   (byte_value),
        .cmd          (cmd),
        .status       (status),
        .out_byte     (out_byte),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

// ===== src/mfe_checker.sv =====
// ----------------------------------------------------------------------------
// Manchester frame encoder checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "manchester_frame_encoder_defines.svh"

module mfe_checker
    import mfe_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_stall,
    input logic [1:0] mode,
    input logic       result_valid,
    input logic       result_stall,
    input logic [7:0] out_byte,
    input logic       last
);

    // Stalled result holds
    `MFE_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(out_byte) && $stable(last), "stalled result changed")

    // No item is taken while a result is stuck in the output register
    `MFE_ASSERT_NOW(a_no_accept_when_full, result_valid && result_stall, item_stall, "item accepted while output blocked")

    // Trailer byte is always 0x00
    `MFE_ASSERT_NOW(a_trailer_value, result_valid && last, out_byte == TRAILER_BYTE, "last flagged on a non-trailer byte")

    // A start item puts the header in the output register next cycle
    `MFE_ASSERT_NEXT(a_start_header, item_valid && !item_stall && mode == MODE_START, result_valid && out_byte == HEADER_BYTE && !last, "start item did not emit header")

endmodule

bind manchester_frame_encoder mfe_checker u_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Manchester frame encoder testbench
// Drives start, payload and end transactions into the encoder with random
// gaps and receiver stalls. A shadow frame model predicts every output byte,
// and each accepted result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import mfe_pkg::*;

    localparam int         PAYLOAD_BYTES = 16;
    localparam int         RANDOM_ITEMS  = 45;
    localparam int         HOLD_CYCLES   = 150;
    localparam int         DRAIN_LIMIT   = 20000;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       item_valid   = 1'b0;
    logic [1:0] mode         = 2'd0;
    logic [7:0] byte_value   = 8'h00;
    logic       result_stall = 1'b0;
    logic       item_stall;
    logic       result_valid;
    logic [7:0] out_byte;
    logic       last;

    // Shadow frame state and pending output bytes
    logic        frame_open   = 1'b0;
    logic [4:0]  slots_filled = '0;
    frame_byte_t frame_bytes[$];

    int  mismatches      = 0;
    int  results_checked = 0;
    int  frames_closed   = 0;
    int  coded_items     = 0;
    bit  no_idle         = 1'b0;
    bit  hold_req        = 1'b0;

    manchester_frame_encoder #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .byte_value   (byte_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .last         (last)
    );

    always #6 clk = ~clk;

    // Manchester code of one nibble, MSB pair in the top bits
    function automatic logic [7:0] manchester_nibble(input logic [3:0] nib);
        logic [7:0] coded;
        for (int k = 0; k < 4; k++)
        begin
            coded[2*k +: 2] = nib[k] ? PAIR_ONE : PAIR_ZERO;
        end
        return coded;
    endfunction

    function automatic void push_frame_byte(input logic [7:0] data, input logic is_last);
        frame_byte_t fb;
        fb.data = data;
        fb.last = is_last;
        frame_bytes.push_back(fb);
    endfunction

    function automatic void push_coded(input logic [7:0] v);
        push_frame_byte(manchester_nibble(v[7:4]), 1'b0);
        push_frame_byte(manchester_nibble(v[3:0]), 1'b0);
    endfunction

    // Expected frame bytes for one accepted transaction
    function automatic void predict_frame_bytes(input logic [1:0] m, input logic [7:0] v);
        case (m)
            MODE_START:
            begin
                // a start inside a frame simply abandons it
                frame_open   = 1'b1;
                slots_filled = '0;
                push_frame_byte(HEADER_BYTE, 1'b0);
                push_coded(v);
                coded_items++;
            end
            MODE_PAYLOAD:
            begin
                // dropped once the payload is full or outside a frame
                if (frame_open && slots_filled < PAYLOAD_BYTES)
                begin
                    push_coded(v);
                    slots_filled++;
                    coded_items++;
                end
            end
            MODE_END:
            begin
                if (frame_open)
                begin
                    while (slots_filled < PAYLOAD_BYTES)
                    begin
                        push_coded(8'h00);
                        slots_filled++;
                    end
                    push_frame_byte(TRAILER_BYTE, 1'b1);
                    frame_open   = 1'b0;
                    slots_filled = '0;
                    frames_closed++;
                    coded_items++;
                end
            end
            default:
            begin
                // unused mode, nothing happens
            end
        endcase
    endfunction

    function automatic void flag_mismatch(input string msg);
        if (mismatches < 10)
        begin
            $display("[%0t] %s", $realtime, msg);
        end
        mismatches++;
    endfunction

    // Result check first, then prediction from the transaction taken at this edge
    always @(posedge clk)
    begin
        frame_byte_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                results_checked++;
                if (frame_bytes.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected byte %02h last %0b", out_byte, last));
                end
                else
                begin
                    want = frame_bytes.pop_front();
                    if (out_byte !== want.data)
                    begin
                        flag_mismatch($sformatf("out_byte expected %02h got %02h",
                                                want.data, out_byte));
                    end
                    if (last !== want.last)
                    begin
                        flag_mismatch($sformatf("last expected %0b got %0b (byte %02h)",
                                                want.last, last, out_byte));
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                predict_frame_bytes(mode, byte_value);
            end
        end
    end

    // Receiver: random stalls, or one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
                hold_req     <= 1'b0;
            end
            else
            begin
                result_stall <= !no_idle && ($urandom_range(99) < 13);
            end
        end
    end

    // Send one transaction, with an optional random gap in front
    task automatic send_item(input logic [1:0] m, input logic [7:0] v);
        while (!no_idle && $urandom_range(99) < 13)
        begin
            item_valid <= 1'b0;
            mode       <= 2'($urandom_range(3));
            byte_value <= 8'($urandom_range(255));
            @(posedge clk);
        end
        item_valid <= 1'b1;
        mode       <= m;
        byte_value <= v;
        @(posedge clk);
        while (item_stall) @(posedge clk);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (frame_bytes.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (frame_bytes.size() != 0)
        begin
            flag_mismatch($sformatf("%0d frame bytes never arrived", frame_bytes.size()));
        end
    endtask

    // Payload, end and unused mode while no frame is open
    task automatic test_outside_frame();
        send_item(MODE_PAYLOAD, 8'hFF);
        send_item(MODE_END, 8'h00);
        send_item(MODE_UNUSED, 8'h5A);
    endtask

    // Restart of an open frame, then an empty frame padded to full length
    task automatic test_restart();
        send_item(MODE_START, 8'h00);
        send_item(MODE_START, 8'h7E);
        send_item(MODE_END, 8'hFF);
    endtask

    // Full payload with extreme bytes, one overflow byte, unused mode inside
    task automatic test_full_frame_overflow();
        logic [7:0] pattern[4] = '{8'h55, 8'hAA, 8'h80, 8'h01};
        send_item(MODE_START, 8'hFF);
        send_item(MODE_PAYLOAD, 8'h00);
        send_item(MODE_PAYLOAD, 8'hFF);
        for (int i = 0; i < PAYLOAD_BYTES - 2; i++)
        begin
            send_item(MODE_PAYLOAD, pattern[i % 4]);
        end
        send_item(MODE_PAYLOAD, 8'hC3);
        send_item(MODE_UNUSED, 8'hFF);
        send_item(MODE_END, 8'h00);
    endtask

    // Long receiver hold-off while a full frame is offered
    task automatic test_backpressure();
        hold_req <= 1'b1;
        send_item(MODE_START, 8'($urandom_range(255)));
        repeat (PAYLOAD_BYTES) send_item(MODE_PAYLOAD, 8'($urandom_range(255)));
        send_item(MODE_END, 8'($urandom_range(255)));
    endtask

    // Back-to-back traffic with no gaps and no stalls
    task automatic test_no_idle_stretch();
        no_idle = 1'b1;
        repeat (3)
        begin
            send_item(MODE_START, 8'($urandom_range(255)));
            repeat ($urandom_range(PAYLOAD_BYTES))
                send_item(MODE_PAYLOAD, 8'($urandom_range(255)));
            send_item(MODE_END, 8'($urandom_range(255)));
        end
        no_idle = 1'b0;
    endtask

    // Mostly well-formed messages with random content, some noise
    task automatic test_random_frames();
        int base;
        int n_pay;
        base = coded_items;
        while (coded_items - base < RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 80)
            begin
                send_item(MODE_START, 8'($urandom_range(255)));
                if ($urandom_range(9) == 0)
                begin
                    n_pay = $urandom_range(PAYLOAD_BYTES + 4);
                end
                else
                begin
                    n_pay = $urandom_range(PAYLOAD_BYTES);
                end
                repeat (n_pay) send_item(MODE_PAYLOAD, 8'($urandom_range(255)));
                // sometimes leave the frame open so the next start restarts it
                if ($urandom_range(9) != 0)
                begin
                    send_item(MODE_END, 8'($urandom_range(255)));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_outside_frame();
        test_restart();
        test_full_frame_overflow();
        test_backpressure();
        test_no_idle_stretch();
        test_random_frames();

        item_valid <= 1'b0;
        @(posedge clk);
        wait_drained();
        repeat (40) @(posedge clk);
        if (frame_bytes.size() != 0)
        begin
            flag_mismatch($sformatf("%0d frame bytes left over", frame_bytes.size()));
        end

        $display("Run covered %0d closed frames and %0d checked output bytes,",
                 frames_closed, results_checked);
        $display("including restarts, payload overflow, idle items and a long hold-off.");
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
